// ===== src/i2cu_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cu_pkg
// Shared constants and types of the im2col unpack engine: store geometry,
// request codes, register indexes, the configuration bundle and the queue
// entry passed from the front end to the back end.
// ----------------------------------------------------------------------------
package i2cu_pkg;

    localparam int IMAGE_WORDS = 4096;
    localparam int DATA_WIDTH  = 32;
    localparam int ADDR_W      = $clog2(IMAGE_WORDS);
    localparam int LP_W        = $clog2(IMAGE_WORDS + 1);

    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    localparam int CFG_ADDR_W  = 5;

    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_FETCH  = 2'd1;
    localparam logic [1:0] FUNC_REWIND = 2'd2;

    localparam logic [2:0] REG_CHANNELS      = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd2;
    localparam logic [2:0] REG_KERNEL_SIZE   = 3'd3;
    localparam logic [2:0] REG_OUT_ROWS      = 3'd4;
    localparam logic [2:0] REG_OUT_COLS      = 3'd5;
    localparam logic [2:0] REG_PADDING       = 3'd6;
    localparam logic [2:0] REG_STRIDE        = 3'd7;

    typedef struct packed {
        logic [8:0]  channels;
        logic [7:0]  image_height;
        logic [7:0]  image_width;
        logic [15:0] kernel_size;
        logic [7:0]  out_rows;
        logic [7:0]  out_cols;
        logic [15:0] padding;
        logic [15:0] stride;
    } cfg_t;

    typedef struct packed {
        logic                  is_load;
        logic [ADDR_W-1:0]     addr;
        logic [DATA_WIDTH-1:0] pixel;
        logic                  zero;
        logic                  pad;
        logic                  last;
    } op_t;

endpackage

// ===== src/i2cu_fifo.sv =====
// ----------------------------------------------------------------------------
// i2cu_fifo
// Short first-in first-out queue of operations between the front end and
// the back end, with an occupancy count for the front end's credit check.
// ----------------------------------------------------------------------------
module i2cu_fifo
    import i2cu_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  op_t                   push_op,
    input  logic                  pop,
    output op_t                   head_op,
    output logic                  head_valid,
    output logic [FIFO_CNT_W-1:0] count
);

    op_t                   entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    assign head_op    = entry_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign count      = count_reg;

endmodule

// ===== src/i2cu_front.sv =====
// ----------------------------------------------------------------------------
// i2cu_front
// Front end: accepts requests, keeps the load pointer and the five fetch
// counters, and turns each load or fetch into a queue entry over two steps
// (image position, then store address and padding check).
// ----------------------------------------------------------------------------
module i2cu_front
    import i2cu_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cfg_t                  cfg,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,  // pixel[31:0]
    input  logic [1:0]            s_tuser,  // func[1:0]
    input  logic [FIFO_CNT_W-1:0] fifo_count,
    output logic                  push,
    output op_t                   push_op
);

    logic [LP_W-1:0] load_ptr_reg, load_ptr_next;
    logic [7:0]      ch_reg, ch_next;
    logic [7:0]      krow_reg, krow_next;
    logic [7:0]      kcol_reg, kcol_next;
    logic [7:0]      orow_reg, orow_next;
    logic [7:0]      ocol_reg, ocol_next;

    logic                  v1_reg, v1_next;
    logic                  is_load1_reg;
    logic [ADDR_W-1:0]     ld_addr1_reg;
    logic [DATA_WIDTH-1:0] pixel1_reg;
    logic signed [17:0]    r1_reg, r1_next;
    logic signed [17:0]    c1_reg, c1_next;
    logic [15:0]           chh1_reg, chh1_next;
    logic                  last1_reg, last1_next;

    logic       fire, do_load, do_fetch;
    logic [8:0] nch;
    logic [7:0] krows, kcols, orows, ocols;
    logic       wc, wr, wkc, wkr, wch;
    logic [15:0] rmul, cmul;
    logic       in_img;
    logic [16:0] row_base;
    logic [24:0] addr_full;

    assign s_tready = ({1'b0, fifo_count} + {{FIFO_CNT_W{1'b0}}, v1_reg})
                      < (FIFO_CNT_W + 1)'(FIFO_DEPTH);
    assign fire     = s_tvalid && s_tready;
    assign do_load  = fire && (s_tuser == FUNC_LOAD) &&
                      (load_ptr_reg < LP_W'(IMAGE_WORDS));
    assign do_fetch = fire && (s_tuser == FUNC_FETCH);

    always_comb begin
        if (cfg.channels == 9'd0) begin
            nch = 9'd1;
        end else if (cfg.channels > 9'd256) begin
            nch = 9'd256;
        end else begin
            nch = cfg.channels;
        end
        krows = (cfg.kernel_size[7:0] == 8'd0) ? 8'd1 : cfg.kernel_size[7:0];
        kcols = (cfg.kernel_size[15:8] == 8'd0) ? 8'd1 : cfg.kernel_size[15:8];
        orows = (cfg.out_rows == 8'd0) ? 8'd1 : cfg.out_rows;
        ocols = (cfg.out_cols == 8'd0) ? 8'd1 : cfg.out_cols;

        wc  = ({1'b0, ocol_reg} + 9'd1) >= {1'b0, ocols};
        wr  = ({1'b0, orow_reg} + 9'd1) >= {1'b0, orows};
        wkc = ({1'b0, kcol_reg} + 9'd1) >= {1'b0, kcols};
        wkr = ({1'b0, krow_reg} + 9'd1) >= {1'b0, krows};
        wch = ({1'b0, ch_reg} + 9'd1) >= nch;
        last1_next = wc && wr && wkc && wkr && wch;

        rmul      = orow_reg * cfg.stride[7:0];
        cmul      = ocol_reg * cfg.stride[15:8];
        r1_next   = $signed({2'b0, rmul}) + $signed({10'b0, krow_reg})
                    - $signed({10'b0, cfg.padding[7:0]});
        c1_next   = $signed({2'b0, cmul}) + $signed({10'b0, kcol_reg})
                    - $signed({10'b0, cfg.padding[15:8]});
        chh1_next = ch_reg * cfg.image_height;

        load_ptr_next = load_ptr_reg;
        ch_next       = ch_reg;
        krow_next     = krow_reg;
        kcol_next     = kcol_reg;
        orow_next     = orow_reg;
        ocol_next     = ocol_reg;
        if (fire && (s_tuser == FUNC_REWIND)) begin
            load_ptr_next = '0;
            ch_next       = '0;
            krow_next     = '0;
            kcol_next     = '0;
            orow_next     = '0;
            ocol_next     = '0;
        end else if (do_load) begin
            load_ptr_next = load_ptr_reg + 1'b1;
        end else if (do_fetch) begin
            ocol_next = wc ? 8'd0 : ocol_reg + 8'd1;
            if (wc) begin
                orow_next = wr ? 8'd0 : orow_reg + 8'd1;
            end
            if (wc && wr) begin
                kcol_next = wkc ? 8'd0 : kcol_reg + 8'd1;
            end
            if (wc && wr && wkc) begin
                krow_next = wkr ? 8'd0 : krow_reg + 8'd1;
            end
            if (wc && wr && wkc && wkr) begin
                ch_next = wch ? 8'd0 : ch_reg + 8'd1;
            end
        end
        v1_next = do_load || do_fetch;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_ptr_reg <= '0;
            ch_reg       <= '0;
            krow_reg     <= '0;
            kcol_reg     <= '0;
            orow_reg     <= '0;
            ocol_reg     <= '0;
            v1_reg       <= 1'b0;
        end else begin
            load_ptr_reg <= load_ptr_next;
            ch_reg       <= ch_next;
            krow_reg     <= krow_next;
            kcol_reg     <= kcol_next;
            orow_reg     <= orow_next;
            ocol_reg     <= ocol_next;
            v1_reg       <= v1_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (v1_next) begin
            is_load1_reg <= do_load;
            ld_addr1_reg <= load_ptr_reg[ADDR_W-1:0];
            pixel1_reg   <= s_tdata[DATA_WIDTH-1:0];
            r1_reg       <= r1_next;
            c1_reg       <= c1_next;
            chh1_reg     <= chh1_next;
            last1_reg    <= last1_next;
        end
    end

    always_comb begin
        in_img    = (r1_reg >= 18'sd0) && (r1_reg < $signed({10'b0, cfg.image_height})) &&
                    (c1_reg >= 18'sd0) && (c1_reg < $signed({10'b0, cfg.image_width}));
        row_base  = {1'b0, chh1_reg} + {9'b0, r1_reg[7:0]};
        addr_full = ({8'b0, row_base} * {17'b0, cfg.image_width}) + {17'b0, c1_reg[7:0]};

        push            = v1_reg;
        push_op.is_load = is_load1_reg;
        push_op.addr    = is_load1_reg ? ld_addr1_reg : addr_full[ADDR_W-1:0];
        push_op.pixel   = pixel1_reg;
        push_op.pad     = !in_img;
        push_op.zero    = !in_img || (addr_full >= 25'(IMAGE_WORDS));
        push_op.last    = last1_reg;
    end

endmodule

// ===== src/i2cu_back.sv =====
// ----------------------------------------------------------------------------
// i2cu_back
// Back end: drains the queue, writes loads into the image store, reads the
// store for fetches and presents the element through a registered output.
// ----------------------------------------------------------------------------
module i2cu_back
    import i2cu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  op_t         head_op,
    input  logic        head_valid,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // value[31:0]
    output logic        m_tuser,  // in_padding
    output logic        m_tlast
);

    logic [DATA_WIDTH-1:0] store [IMAGE_WORDS];

    logic                  rv_reg, rv_next;
    logic [DATA_WIDTH-1:0] rdata_reg;
    logic                  rzero_reg, rpad_reg, rlast_reg;

    logic                  ov_reg, ov_next;
    logic [DATA_WIDTH-1:0] value_reg;
    logic                  pad_reg, last_reg;

    logic adv_out, rd_ready, pop_fetch, pop_load;

    always_comb begin
        adv_out   = !ov_reg || m_tready;
        rd_ready  = !rv_reg || adv_out;
        pop_load  = head_valid && head_op.is_load;
        pop_fetch = head_valid && !head_op.is_load && rd_ready;
        pop       = pop_load || pop_fetch;

        rv_next = rv_reg;
        if (pop_fetch) begin
            rv_next = 1'b1;
        end else if (adv_out) begin
            rv_next = 1'b0;
        end

        ov_next = ov_reg;
        if (rv_reg && adv_out) begin
            ov_next = 1'b1;
        end else if (m_tready) begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else begin
            rv_reg <= rv_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_load) begin
            store[head_op.addr] <= head_op.pixel;
        end
        if (pop_fetch) begin
            rdata_reg <= store[head_op.addr];
            rzero_reg <= head_op.zero;
            rpad_reg  <= head_op.pad;
            rlast_reg <= head_op.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (rv_reg && adv_out) begin
            value_reg <= rzero_reg ? '0 : rdata_reg;
            pad_reg   <= rpad_reg;
            last_reg  <= rlast_reg;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = value_reg;
    assign m_tuser  = pad_reg;
    assign m_tlast  = last_reg;

endmodule

// ===== src/im2col_unpack_engine.sv =====
// ----------------------------------------------------------------------------
// im2col_unpack_engine
// Path: a fetch passes the front-end register, queue, read and output registers.
// Throughput: one request per cycle; the four-entry queue and output register
// set how far each side can stall before s_tready drops.
// Reset: synchronous, active low; clears pointers, counters, valid flags and the
// configuration to their defaults. The image store is not cleared.
// ----------------------------------------------------------------------------
module im2col_unpack_engine
    import i2cu_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,  // pixel[31:0]
    input  logic [1:0]            s_tuser,  // func[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,  // value[31:0]
    output logic                  m_tuser,  // in_padding
    output logic                  m_tlast
);

    cfg_t                  cfg_reg, cfg_next;
    logic                  cfg_wr;
    logic [2:0]            reg_idx;
    logic                  push, pop, head_valid;
    op_t                   push_op, head_op;
    logic [FIFO_CNT_W-1:0] fifo_count;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr) begin
            case (reg_idx)
                REG_CHANNELS:      cfg_next.channels      = pwdata[8:0];
                REG_IMAGE_HEIGHT:  cfg_next.image_height  = pwdata[7:0];
                REG_IMAGE_WIDTH:   cfg_next.image_width   = pwdata[7:0];
                REG_KERNEL_SIZE:   cfg_next.kernel_size   = pwdata[15:0];
                REG_OUT_ROWS:      cfg_next.out_rows      = pwdata[7:0];
                REG_OUT_COLS:      cfg_next.out_cols      = pwdata[7:0];
                REG_PADDING:       cfg_next.padding       = pwdata[15:0];
                REG_STRIDE:        cfg_next.stride        = pwdata[15:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_CHANNELS:      prdata = {23'b0, cfg_reg.channels};
            REG_IMAGE_HEIGHT:  prdata = {24'b0, cfg_reg.image_height};
            REG_IMAGE_WIDTH:   prdata = {24'b0, cfg_reg.image_width};
            REG_KERNEL_SIZE:   prdata = {16'b0, cfg_reg.kernel_size};
            REG_OUT_ROWS:      prdata = {24'b0, cfg_reg.out_rows};
            REG_OUT_COLS:      prdata = {24'b0, cfg_reg.out_cols};
            REG_PADDING:       prdata = {16'b0, cfg_reg.padding};
            REG_STRIDE:        prdata = {16'b0, cfg_reg.stride};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.channels      <= 9'd1;
            cfg_reg.image_height  <= 8'd1;
            cfg_reg.image_width   <= 8'd1;
            cfg_reg.kernel_size   <= 16'd257;
            cfg_reg.out_rows      <= 8'd1;
            cfg_reg.out_cols      <= 8'd1;
            cfg_reg.padding       <= 16'd0;
            cfg_reg.stride        <= 16'd257;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    i2cu_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .fifo_count (fifo_count),
        .push       (push),
        .push_op    (push_op)
    );

    i2cu_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_op    (push_op),
        .pop        (pop),
        .head_op    (head_op),
        .head_valid (head_valid),
        .count      (fifo_count)
    );

    i2cu_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_op    (head_op),
        .head_valid (head_valid),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
